// ===== hw/rtl/record_insertion_sorter_defines.svh =====
// assertion macros used by the sorter controller
`ifndef RECORD_INSERTION_SORTER_DEFINES_SVH
`define RECORD_INSERTION_SORTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RIS_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("sorter check failed");

// next-cycle implication, disabled during reset
`define RIS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("sorter check failed");

`endif

// ===== hw/rtl/ris_pkg.sv =====
package ris_pkg;

   localparam int DEPTH_DEFAULT    = 64;
   localparam int TAG_BITS_DEFAULT = 16;
   localparam int KEY_BITS         = 12;
   localparam int PORT_TAG_BITS    = 16;

   // one input beat
   typedef struct packed {
      logic [KEY_BITS-1:0]      year_key;
      logic [PORT_TAG_BITS-1:0] record_tag;
      logic                     last_record;
   } req_payload_type;

   // one result beat
   typedef struct packed {
      logic [KEY_BITS-1:0]      sorted_year;
      logic [PORT_TAG_BITS-1:0] sorted_tag;
      logic                     final_result;
      logic                     overflowed;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic insert;
      logic emit;
      logic overflow;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic one_left;
   } status_type;

endpackage

// ===== hw/rtl/record_insertion_sorter.sv =====
// channel   ports                               direction  handshake
// request   start, busy, req_payload            in         beat taken when start && !busy
// response  rsp_strobe, rsp_payload             out        one-cycle strobe, no back-pressure
//
// collecting: one record a cycle, busy stays low; each beat is placed in a sorted
//   shift chain by a parallel compare against every slot in the same cycle
// closing beat: busy rises on the next cycle and the chain drains from its head,
//   one result per cycle, so a set of n records gives n strobes (DEPTH at most)
//   via the state and result registers; busy falls in the same cycle as the final result strobe
// reset is synchronous and active high; it empties the chain and clears overflow
// results cannot be stalled: the receiver must take each strobe as it comes
module record_insertion_sorter #(
   parameter int DEPTH    = ris_pkg::DEPTH_DEFAULT,
   parameter int TAG_BITS = ris_pkg::TAG_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  ris_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output ris_pkg::rsp_payload_type rsp_payload
);

   // command and status between the sequencer and the sort chain
   ris_pkg::cmd_type    cmd;
   ris_pkg::status_type status;

   // sequencer: collect/emit, overflow tracking, busy
   ris_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_record (req_payload.last_record),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // sort chain with valid bits and the registered result beat
   ris_datapath #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/ris_datapath.sv =====
module ris_datapath #(
   parameter int DEPTH    = ris_pkg::DEPTH_DEFAULT,
   parameter int TAG_BITS = ris_pkg::TAG_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ris_pkg::req_payload_type req_payload,
   input  ris_pkg::cmd_type         cmd,
   output ris_pkg::status_type      status,
   output logic                     rsp_strobe,
   output ris_pkg::rsp_payload_type rsp_payload
);

   localparam int KEY_BITS = ris_pkg::KEY_BITS;

   logic [KEY_BITS-1:0] key_ff [DEPTH];
   logic [KEY_BITS-1:0] key_in [DEPTH];
   logic [TAG_BITS-1:0] tag_ff [DEPTH];
   logic [TAG_BITS-1:0] tag_in [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [DEPTH-1:0]    valid_in;
   logic [DEPTH-1:0]    move;
   logic [TAG_BITS-1:0] new_tag;

   logic                     rsp_strobe_ff;
   ris_pkg::rsp_payload_type rsp_payload_ff;
   ris_pkg::rsp_payload_type rsp_payload_in;

   assign new_tag = TAG_BITS'(req_payload.record_tag);

   // empty slots and strictly greater keys move up, so equal keys stay in order
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         move[i] = !valid_ff[i] || (key_ff[i] > req_payload.year_key);
      end
   end

   always_comb begin
      key_in   = key_ff;
      tag_in   = tag_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (move[0]) begin
            key_in[0] = req_payload.year_key;
            tag_in[0] = new_tag;
         end
         valid_in[0] = 1'b1;
         for (int i = 1; i < DEPTH; i++) begin
            if (move[i]) begin
               if (!move[i-1]) begin
                  key_in[i] = req_payload.year_key;
                  tag_in[i] = new_tag;
               end else begin
                  key_in[i] = key_ff[i-1];
                  tag_in[i] = tag_ff[i-1];
               end
            end
            valid_in[i] = valid_ff[i] | valid_ff[i-1];
         end
      end else if (cmd.emit) begin
         // drain toward the head
         for (int i = 0; i < DEPTH - 1; i++) begin
            key_in[i]   = key_ff[i+1];
            tag_in[i]   = tag_ff[i+1];
            valid_in[i] = valid_ff[i+1];
         end
         valid_in[DEPTH-1] = 1'b0;
      end
   end

   always_comb begin
      rsp_payload_in.sorted_year  = key_ff[0];
      rsp_payload_in.sorted_tag   = ris_pkg::PORT_TAG_BITS'(tag_ff[0]);
      rsp_payload_in.final_result = status.one_left;
      rsp_payload_in.overflowed   = cmd.overflow;
   end

   assign status.full     = valid_ff[DEPTH-1];
   assign status.one_left = valid_ff[0] & ~valid_ff[1];

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
      if (cmd.emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      if (reset) begin
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hw/rtl/ris_controller.sv =====
`include "record_insertion_sorter_defines.svh"

module ris_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last_record,
   input  ris_pkg::status_type status,
   output ris_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic {
      COLLECT,
      EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;
   logic      overflow_ff;
   logic      overflow_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in    = state_ff;
      busy_in     = busy_ff;
      overflow_in = overflow_ff;
      cmd.insert  = 1'b0;
      cmd.emit    = 1'b0;
      cmd.overflow = overflow_ff;
      case (state_ff)
         COLLECT: begin
            if (accept) begin
               cmd.insert = !status.full;
               if (status.full) begin
                  overflow_in = 1'b1;
               end
               if (last_record) begin
                  state_in = EMIT;
                  busy_in  = 1'b1;
               end
            end
         end
         EMIT: begin
            cmd.emit = 1'b1;
            if (status.one_left) begin
               state_in    = COLLECT;
               busy_in     = 1'b0;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in    = COLLECT;
            busy_in     = 1'b0;
            overflow_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= COLLECT;
         busy_ff     <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         busy_ff     <= busy_in;
         overflow_ff <= overflow_in;
      end
   end

   assign busy = busy_ff;

   `RIS_ASSERT_SAME(a_no_insert_when_full, clock, reset, cmd.insert, !status.full)
   `RIS_ASSERT_SAME(a_busy_while_emitting, clock, reset, state_ff == EMIT, busy_ff && cmd.emit)
   `RIS_ASSERT_NEXT(a_idle_after_final, clock, reset, cmd.emit && status.one_left,
                    !busy_ff && !overflow_ff)
   `RIS_ASSERT_NEXT(a_closing_beat_goes_busy, clock, reset, accept && last_record, busy_ff)

endmodule

// ===== tb/tb_record_insertion_sorter.sv =====
module tb_record_insertion_sorter;

   // chain size and tag width as the block is built here
   localparam int CHAIN_DEPTH    = ris_pkg::DEPTH_DEFAULT;
   localparam int TAG_KEEP       = ris_pkg::TAG_BITS_DEFAULT;
   localparam int RANDOM_RECORDS = 450;
   localparam int MAX_GAP        = 40;
   // a full chain gives CHAIN_DEPTH strobes; the settle wait covers them with slack
   localparam int SETTLE_CYCLES  = CHAIN_DEPTH + 8;
   localparam int CYCLE_LIMIT    = 200000;

   // one line of the directed table: the beat, and where it can be read off
   // at a glance, the single result it must give
   typedef struct packed {
      ris_pkg::req_payload_type beat;
      logic                     typed;
      ris_pkg::rsp_payload_type want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   ris_pkg::req_payload_type req_payload = '0;
   logic                     rsp_strobe;
   ris_pkg::rsp_payload_type rsp_payload;

   record_insertion_sorter DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor: a sorted chain of its own, filled one record per beat
   // ---------------------------------------------------------------------
   logic [ris_pkg::KEY_BITS-1:0]      year_chain [CHAIN_DEPTH];
   logic [ris_pkg::PORT_TAG_BITS-1:0] tag_chain  [CHAIN_DEPTH];
   int unsigned                       chain_count    = 0;
   logic                              chain_overflow = 1'b0;

   ris_pkg::rsp_payload_type sorted_expect [$];   // results still owed by the block
   ris_pkg::rsp_payload_type fresh_run [$];       // run released by the latest beat
   stim_row_type             pending_notes [$];   // one note per beat in flight, with its typed result

   int unsigned mismatch_count = 0;
   int unsigned sender_idle_pct = 23;
   int unsigned cycle_count    = 0;

   function automatic void sort_record(input ris_pkg::req_payload_type beat);
      int unsigned                       slot;
      int unsigned                       i;
      logic [ris_pkg::PORT_TAG_BITS-1:0] kept_tag;
      ris_pkg::rsp_payload_type          res;
      kept_tag = beat.record_tag & ris_pkg::PORT_TAG_BITS'((64'd1 << TAG_KEEP) - 1);
      fresh_run.delete();
      if (chain_count == CHAIN_DEPTH) begin
         // chain full: the record is lost, the set is marked
         chain_overflow = 1'b1;
      end else begin
         // goes after every key less than or equal to its own, so ties keep arrival order
         slot = chain_count;
         for (i = 0; i < chain_count; i++) begin
            if (year_chain[i] > beat.year_key) begin
               slot = i;
               break;
            end
         end
         for (i = chain_count; i > slot; i--) begin
            year_chain[i] = year_chain[i-1];
            tag_chain[i]  = tag_chain[i-1];
         end
         year_chain[slot] = beat.year_key;
         tag_chain[slot]  = kept_tag;
         chain_count++;
      end
      if (beat.last_record) begin
         // closing beat releases the whole chain, then the set starts afresh
         for (i = 0; i < chain_count; i++) begin
            res.sorted_year  = year_chain[i];
            res.sorted_tag   = tag_chain[i];
            res.final_result = (i + 1 == chain_count);
            res.overflowed   = chain_overflow;
            fresh_run        = {fresh_run, res};
         end
         chain_count    = 0;
         chain_overflow = 1'b0;
      end
   endfunction

   task automatic compare_field(input string field_name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // monitor: results are checked first, then any beat taken at this edge
   // is fed to the predictor; all values are the ones from before the edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stim_row_type             note;
      ris_pkg::rsp_payload_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (sorted_expect.size() == 0) begin
               $display("%0t: result expected none actual %0h/%0h/%0b/%0b", $time,
                        rsp_payload.sorted_year, rsp_payload.sorted_tag,
                        rsp_payload.final_result, rsp_payload.overflowed);
               mismatch_count++;
            end else begin
               want = sorted_expect.pop_front();
               compare_field("sorted_year", 32'(want.sorted_year),
                             32'(rsp_payload.sorted_year));
               compare_field("sorted_tag", 32'(want.sorted_tag),
                             32'(rsp_payload.sorted_tag));
               compare_field("final_result", 32'(want.final_result),
                             32'(rsp_payload.final_result));
               compare_field("overflowed", 32'(want.overflowed),
                             32'(rsp_payload.overflowed));
            end
         end
         if (start && !busy) begin
            note = pending_notes.pop_front();
            sort_record(req_payload);
            if (note.typed) begin
               sorted_expect = {sorted_expect, note.want};
            end else begin
               sorted_expect = {sorted_expect, fresh_run};
            end
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // driver: optional idle gap, then hold the beat until busy is low at an edge
   // start is only lowered when a gap follows, so it never toggles within a step
   // ---------------------------------------------------------------------
   task automatic send_record(input ris_pkg::req_payload_type beat, input logic typed,
                              input ris_pkg::rsp_payload_type want);
      int unsigned  gap;
      stim_row_type note;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.beat     = beat;
      note.typed    = typed;
      note.want     = want;
      pending_notes = {pending_notes, note};
      start       <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (busy);
   endtask

   // directed table: lone records at the extremes, ties, reversed and
   // ascending sets; a lone closing beat gives one result, read off directly
   stim_row_type directed_rows [0:19] = '{
      '{'{12'h000, 16'h0000, 1'b1}, 1'b1, '{12'h000, 16'h0000, 1'b1, 1'b0}},
      '{'{12'hFFF, 16'hFFFF, 1'b1}, 1'b1, '{12'hFFF, 16'hFFFF, 1'b1, 1'b0}},
      '{'{12'hFFF, 16'hAAAA, 1'b0}, 1'b0, '0},
      '{'{12'h000, 16'h5555, 1'b0}, 1'b0, '0},
      '{'{12'h800, 16'h1234, 1'b0}, 1'b0, '0},
      '{'{12'h800, 16'h4321, 1'b0}, 1'b0, '0},
      '{'{12'h800, 16'h0F0F, 1'b1}, 1'b0, '0},
      '{'{12'h005, 16'h0001, 1'b0}, 1'b0, '0},
      '{'{12'h004, 16'h0002, 1'b0}, 1'b0, '0},
      '{'{12'h003, 16'h0003, 1'b0}, 1'b0, '0},
      '{'{12'h002, 16'h0004, 1'b0}, 1'b0, '0},
      '{'{12'h001, 16'h0005, 1'b1}, 1'b0, '0},
      '{'{12'h007, 16'h00A1, 1'b0}, 1'b0, '0},
      '{'{12'h007, 16'h00A2, 1'b0}, 1'b0, '0},
      '{'{12'h007, 16'h00A3, 1'b0}, 1'b0, '0},
      '{'{12'h007, 16'h00A4, 1'b1}, 1'b0, '0},
      '{'{12'hABC, 16'hBEEF, 1'b1}, 1'b1, '{12'hABC, 16'hBEEF, 1'b1, 1'b0}},
      '{'{12'h001, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{12'h002, 16'h7FFF, 1'b0}, 1'b0, '0},
      '{'{12'h003, 16'hC3C3, 1'b1}, 1'b0, '0}
   };

   initial begin
      ris_pkg::req_payload_type     beat;
      int unsigned                  set_index;
      int unsigned                  set_size;
      int unsigned                  random_sent;
      logic                         narrow_keys;
      logic [ris_pkg::KEY_BITS-1:0] key_base;
      int unsigned                  waited;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_record(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
      end

      // random sets: mostly short, one exactly full, one whose closing beat
      // falls on a full chain, and now and then one that spills over
      set_index   = 0;
      random_sent = 0;
      while (random_sent < RANDOM_RECORDS) begin
         // sender idling by thirds: light, heavy, then none at all
         if (random_sent < RANDOM_RECORDS / 3)          sender_idle_pct = 23;
         else if (random_sent < 2 * RANDOM_RECORDS / 3) sender_idle_pct = 52;
         else                                           sender_idle_pct = 0;

         if (set_index == 3)                set_size = CHAIN_DEPTH;
         else if (set_index == 7)           set_size = CHAIN_DEPTH + 1;
         else if ($urandom_range(14) == 0)  set_size = $urandom_range(CHAIN_DEPTH + 8, CHAIN_DEPTH + 2);
         else                               set_size = $urandom_range(12, 1);

         // half the sets crowd their keys together so ties are common
         narrow_keys = 1'($urandom_range(1));
         key_base    = ris_pkg::KEY_BITS'($urandom);
         for (int unsigned n = 0; n < set_size; n++) begin
            if (narrow_keys) begin
               beat.year_key = key_base + ris_pkg::KEY_BITS'($urandom_range(3));
            end else begin
               case ($urandom_range(9))
                  0:       beat.year_key = '0;
                  1:       beat.year_key = '1;
                  default: beat.year_key = ris_pkg::KEY_BITS'($urandom);
               endcase
            end
            beat.record_tag  = ris_pkg::PORT_TAG_BITS'($urandom);
            beat.last_record = (n + 1 == set_size);
            send_record(beat, 1'b0, '0);
            random_sent++;
         end
         set_index++;
      end
      start <= 1'b0;

      // let the last run drain, then watch for stray strobes
      waited = 0;
      while (sorted_expect.size() != 0 && waited < CYCLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && sorted_expect.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ris_pkg.sv
hw/rtl/ris_datapath.sv
hw/rtl/ris_controller.sv
hw/rtl/record_insertion_sorter.sv
tb/tb_record_insertion_sorter.sv
